[rtl/brb_pkg.sv]
// ----------------------------------------------------------------------------
// brb_pkg
// Shared types and constants for the byte ring buffer.
// ----------------------------------------------------------------------------
package brb_pkg;

  localparam int unsigned StoreDepth = 4096;
  localparam int unsigned AddrW      = $clog2(StoreDepth);
  localparam int unsigned CapW       = AddrW + 1;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned OpW        = 3;
  localparam int unsigned StatW      = 2;

  localparam int unsigned InFieldsW  = OpW + AddrW + ByteW;
  localparam int unsigned InDataW    = ((InFieldsW + 7) / 8) * 8;
  localparam int unsigned OutFieldsW = ByteW + StatW + 4 * AddrW;
  localparam int unsigned OutDataW   = ((OutFieldsW + 7) / 8) * 8;

  localparam logic [CapW-1:0] CapReset = CapW'(StoreDepth);
  localparam logic [CapW-1:0] CapMin   = CapW'(2);

  typedef enum logic [OpW-1:0] {
    OpPush   = 3'd0,
    OpPop    = 3'd1,
    OpPoke   = 3'd2,
    OpPeek   = 3'd3,
    OpStatus = 3'd4
  } op_e;

  typedef enum logic [StatW-1:0] {
    StOk    = 2'd0,
    StEmpty = 2'd1,
    StFull  = 2'd2,
    StRange = 2'd3
  } status_e;

endpackage

[rtl/brb_ram.sv]
// ----------------------------------------------------------------------------
// brb_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module brb_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/byte_ring_buffer.sv]
// ----------------------------------------------------------------------------
// byte_ring_buffer
// Byte ring buffer with one slot kept empty, push/pop/poke/peek/status words.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake               | payload
//  s_axis   | in        | tvalid/tready           | tdata (command fields), tlast
//  m_axis   | out       | tvalid/tready           | tdata (status fields), tlast
//  cfg      | in        | cfg_we_i, no wait       | cfg_wdata_i = ring_capacity
//
//  One word per cycle unless the output stalls; each result appears in the cycle
//  after its word is taken, its read byte coming from the store's registered read port.
//  s_axis_tready drops only while a result waits in the output register and
//  m_axis_tready is low; the store read data holds during that stall.
//  Reset clears the pointers and the count and sets the capacity to 4096;
//  the store itself is not cleared.
// ----------------------------------------------------------------------------
module byte_ring_buffer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [brb_pkg::CapW-1:0]      cfg_wdata_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // operation[2:0], slot_index[14:3], write_byte[22:15], zero fill
  input  logic [brb_pkg::InDataW-1:0]   s_axis_tdata,
  input  logic                          s_axis_tlast,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // read_byte[7:0], status_code[9:8], head_position[21:10],
  // tail_position[33:22], readable_count[45:34], writable_count[57:46], zero fill
  output logic [brb_pkg::OutDataW-1:0]  m_axis_tdata,
  output logic                          m_axis_tlast
);

  import brb_pkg::*;

  logic [AddrW-1:0] rp_q, rp_d, wp_q, wp_d, used_q, used_d, cap_m1_q, cap_m1_d;

  logic             out_valid_q, out_valid_d;
  logic             out_rsel_q;
  status_e          out_status_q;
  logic [AddrW-1:0] out_head_q, out_tail_q, out_rdc_q, out_wrc_q;
  logic             out_last_q;

  logic             accept;
  logic [OpW-1:0]   in_op;
  logic [AddrW-1:0] in_idx;
  logic [ByteW-1:0] in_byte;

  logic             idx_ok;
  logic             ram_we, ram_re;
  logic [AddrW-1:0] ram_waddr, ram_raddr;
  logic [ByteW-1:0] ram_rdata;
  status_e          status;
  logic             rsel;

  assign in_op   = s_axis_tdata[OpW-1:0];
  assign in_idx  = s_axis_tdata[OpW +: AddrW];
  assign in_byte = s_axis_tdata[OpW+AddrW +: ByteW];

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign idx_ok        = (in_idx <= cap_m1_q);

  always_comb begin
    rp_d      = rp_q;
    wp_d      = wp_q;
    used_d    = used_q;
    cap_m1_d  = cap_m1_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = in_idx;
    ram_raddr = in_idx;
    status    = StOk;
    rsel      = 1'b0;

    unique case (in_op)
      OpPush: begin
        ram_waddr = wp_q;
        if (used_q == cap_m1_q) begin
          status = StFull;
        end else begin
          ram_we = accept;
          wp_d   = (wp_q == cap_m1_q) ? '0 : wp_q + AddrW'(1);
          used_d = used_q + AddrW'(1);
        end
      end
      OpPop: begin
        ram_raddr = rp_q;
        if (used_q == '0) begin
          status = StEmpty;
        end else begin
          ram_re = accept;
          rsel   = 1'b1;
          rp_d   = (rp_q == cap_m1_q) ? '0 : rp_q + AddrW'(1);
          used_d = used_q - AddrW'(1);
        end
      end
      OpPoke: begin
        if (!idx_ok) begin
          status = StRange;
        end else begin
          ram_we = accept;
        end
      end
      OpPeek: begin
        if (!idx_ok) begin
          status = StRange;
        end else begin
          ram_re = accept;
          rsel   = 1'b1;
        end
      end
      default: begin
      end
    endcase

    if (!accept) begin
      rp_d   = rp_q;
      wp_d   = wp_q;
      used_d = used_q;
    end

    // capacity write empties the ring
    if (cfg_we_i) begin
      rp_d   = '0;
      wp_d   = '0;
      used_d = '0;
      priority if (cfg_wdata_i < CapMin) begin
        cap_m1_d = AddrW'(1);
      end else if (cfg_wdata_i > CapReset) begin
        cap_m1_d = AddrW'(StoreDepth - 1);
      end else begin
        cap_m1_d = AddrW'(cfg_wdata_i - CapW'(1));
      end
    end

    out_valid_d = accept || (out_valid_q && !m_axis_tready);
  end

  brb_ram #(
    .Width (ByteW),
    .Depth (StoreDepth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (in_byte),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rp_q        <= '0;
      wp_q        <= '0;
      used_q      <= '0;
      cap_m1_q    <= AddrW'(StoreDepth - 1);
      out_valid_q <= 1'b0;
    end else begin
      rp_q        <= rp_d;
      wp_q        <= wp_d;
      used_q      <= used_d;
      cap_m1_q    <= cap_m1_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_rsel_q   <= rsel;
      out_status_q <= status;
      out_head_q   <= rp_d;
      out_tail_q   <= wp_d;
      out_rdc_q    <= used_d;
      out_wrc_q    <= cap_m1_q - used_d;
      out_last_q   <= s_axis_tlast;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {
    (OutDataW - OutFieldsW)'(0),
    out_wrc_q, out_rdc_q, out_tail_q, out_head_q, out_status_q,
    (out_rsel_q ? ram_rdata : ByteW'(0))
  };

  a_used_in_ring : assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= cap_m1_q)
    else $error("fill count beyond capacity");

  a_ptrs_in_ring : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rp_q <= cap_m1_q) && (wp_q <= cap_m1_q))
    else $error("pointer beyond capacity");

  a_ptr_count_match : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, rp_q} + {1'b0, used_q} == {1'b0, wp_q}) ||
    ({1'b0, rp_q} + {1'b0, used_q} == {1'b0, wp_q} + {1'b0, cap_m1_q} + CapW'(1)))
    else $error("pointers and fill count disagree");

  a_rdata_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_rsel_q && !m_axis_tready |=> $stable(ram_rdata))
    else $error("store read data changed during output stall");

endmodule

[dv/byte_ring_buffer_checker.sv]
// ----------------------------------------------------------------------------
// byte_ring_buffer_checker
// Watches the configuration port and both stream channels of the byte ring
// buffer. Keeps its own copy of the ring and predicts the status word for each
// accepted command word. Compares each returned word field by field, in order.
// ----------------------------------------------------------------------------
module byte_ring_buffer_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [brb_pkg::CapW-1:0]     cfg_wdata_i,
  input  logic                         s_axis_tvalid,
  input  logic                         s_axis_tready,
  input  logic [brb_pkg::InDataW-1:0]  s_axis_tdata,
  input  logic                         s_axis_tlast,
  input  logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  input  logic [brb_pkg::OutDataW-1:0] m_axis_tdata,
  input  logic                         m_axis_tlast,
  output int unsigned                  error_count_o,
  output int unsigned                  pending_count_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import brb_pkg::*;

  typedef struct packed {
    logic             last;
    logic [AddrW-1:0] writable;
    logic [AddrW-1:0] readable;
    logic [AddrW-1:0] tail;
    logic [AddrW-1:0] head;
    status_e          status;
    logic [ByteW-1:0] data;
  } ring_word_t;

  logic [ByteW-1:0] ring_store [StoreDepth];
  logic [AddrW-1:0] rd_ptr;
  logic [AddrW-1:0] wr_ptr;
  logic [CapW-1:0]  cap_reg;
  ring_word_t       expected_words [$];
  int unsigned      mismatches = 0;

  assign error_count_o = mismatches;

  function automatic int unsigned fill_level(int unsigned lim);
    if (rd_ptr <= wr_ptr) return 32'(wr_ptr) - 32'(rd_ptr);
    return 32'(wr_ptr) + lim - 32'(rd_ptr);
  endfunction

  function automatic logic [AddrW-1:0] next_slot(logic [AddrW-1:0] p, int unsigned lim);
    return (p + 1 >= lim) ? '0 : p + 1'b1;
  endfunction

  function automatic ring_word_t service_word(logic [OpW-1:0] op, logic [AddrW-1:0] idx,
                                              logic [ByteW-1:0] wb, logic last);
    int unsigned lim;
    int unsigned used;
    ring_word_t  r;
    lim = (cap_reg < CapMin) ? CapMin : (cap_reg > StoreDepth) ? StoreDepth : cap_reg;
    used = fill_level(lim);
    r = '0;
    r.status = StOk;
    r.last = last;
    case (op)
      OpPush: begin
        if (used >= lim - 1) begin
          r.status = StFull;
        end else begin
          ring_store[wr_ptr] = wb;
          wr_ptr = next_slot(wr_ptr, lim);
        end
      end
      OpPop: begin
        if (used == 0) begin
          r.status = StEmpty;
        end else begin
          r.data = ring_store[rd_ptr];
          rd_ptr = next_slot(rd_ptr, lim);
        end
      end
      OpPoke: begin
        if (idx >= lim) r.status = StRange;
        else ring_store[idx] = wb;
      end
      OpPeek: begin
        if (idx >= lim) r.status = StRange;
        else r.data = ring_store[idx];
      end
      default: begin
      end
    endcase
    used = fill_level(lim);
    r.head = rd_ptr;
    r.tail = wr_ptr;
    r.readable = AddrW'(used);
    r.writable = AddrW'(lim - 1 - used);
    return r;
  endfunction

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    ring_word_t want;
    ring_word_t got;
    if (!rst_ni) begin
      rd_ptr = '0;
      wr_ptr = '0;
      cap_reg = CapReset;
      expected_words.delete();
      pending_count_o <= 0;
    end else begin
      if (cfg_we_i) begin
        cap_reg = cfg_wdata_i;
        rd_ptr = '0;
        wr_ptr = '0;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tlast, m_axis_tdata[OutFieldsW-1:0]};
        if (expected_words.size() == 0) begin
          $display("%0t: expected no word, got tdata %h tlast %0d", $time,
                   m_axis_tdata, m_axis_tlast);
          mismatches++;
        end else begin
          want = expected_words.pop_front();
          check_field("read_byte", 32'(want.data), 32'(got.data));
          check_field("status_code", 32'(want.status), 32'(got.status));
          check_field("head_position", 32'(want.head), 32'(got.head));
          check_field("tail_position", 32'(want.tail), 32'(got.tail));
          check_field("readable_count", 32'(want.readable), 32'(got.readable));
          check_field("writable_count", 32'(want.writable), 32'(got.writable));
          check_field("last_out", 32'(want.last), 32'(got.last));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        expected_words.push_back(service_word(s_axis_tdata[OpW-1:0],
                                              s_axis_tdata[OpW+AddrW-1:OpW],
                                              s_axis_tdata[InFieldsW-1:OpW+AddrW],
                                              s_axis_tlast));
      end
      pending_count_o <= expected_words.size();
    end
  end

endmodule

[dv/byte_ring_buffer_test.sv]
// ----------------------------------------------------------------------------
// byte_ring_buffer_test
// Drives command words and capacity writes into the byte ring buffer: a short
// directed sequence, a long receiver hold-off, then random phases over several
// capacities and idle/stall mixes. The checker beside the block predicts and
// compares every status word; this module gives the verdict.
// ----------------------------------------------------------------------------
module byte_ring_buffer_test;
  timeunit 1ns;
  timeprecision 1ps;
  import brb_pkg::*;

  localparam int unsigned LimitCycles = 400000;
  localparam int unsigned HoldCycles  = 60;
  localparam int unsigned PhaseWords  = 135;
  localparam logic [OpW-1:0] OpSpare5 = 3'd5;
  localparam logic [OpW-1:0] OpSpare6 = 3'd6;
  localparam logic [OpW-1:0] OpSpare7 = 3'd7;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we = 1'b0;
  logic [CapW-1:0]     cfg_wdata = '0;
  logic                s_valid = 1'b0;
  logic [InDataW-1:0]  s_data = '0;
  logic                s_last = 1'b0;
  logic                m_ready = 1'b0;
  logic                s_ready;
  logic                m_valid;
  logic [OutDataW-1:0] m_data;
  logic                m_last;
  int unsigned         errors;
  int unsigned         pending;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_req = 1'b0;
  int unsigned cap_now = StoreDepth;
  int unsigned call_left = 0;
  bit          slot_poked [StoreDepth];
  int unsigned poked_slots [$];

  byte_ring_buffer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .s_axis_tlast  (s_last),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data),
    .m_axis_tlast  (m_last)
  );

  byte_ring_buffer_checker ring_monitor (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid   (s_valid),
    .s_axis_tready   (s_ready),
    .s_axis_tdata    (s_data),
    .s_axis_tlast    (s_last),
    .m_axis_tvalid   (m_valid),
    .m_axis_tready   (m_ready),
    .m_axis_tdata    (m_data),
    .m_axis_tlast    (m_last),
    .error_count_o   (errors),
    .pending_count_o (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic send_word(input logic [OpW-1:0] op, input logic [AddrW-1:0] idx,
                           input logic [ByteW-1:0] wb, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    if (op == OpPoke && idx < cap_now && !slot_poked[idx]) begin
      slot_poked[idx] = 1'b1;
      poked_slots.push_back(32'(idx));
    end
    s_valid <= 1'b1;
    s_data <= InDataW'({wb, idx, op});
    s_last <= last;
    @(posedge clk_i);
    while (!s_ready) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    s_valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_capacity(input int unsigned value);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= value[CapW-1:0];
    @(posedge clk_i);
    cfg_we <= 1'b0;
    cap_now = (value < CapMin) ? CapMin : (value > StoreDepth) ? StoreDepth : value;
  endtask

  task automatic send_random_word(input bit push_lean);
    int unsigned      roll;
    int unsigned      k;
    logic [OpW-1:0]   op;
    logic [AddrW-1:0] idx;
    logic             last;
    bit               found;
    roll = $urandom_range(99);
    idx = AddrW'($urandom_range(StoreDepth - 1));
    found = 1'b0;
    if (roll < 5) begin
      case ($urandom_range(2))
        0:       op = OpSpare5;
        1:       op = OpSpare6;
        default: op = OpSpare7;
      endcase
    end else if (roll < 10) begin
      op = OpStatus;
    end else if (roll < 30) begin
      op = (roll < 20) ? OpPoke : OpPeek;
      if (cap_now < StoreDepth && $urandom_range(3) == 0) begin
        idx = AddrW'($urandom_range(StoreDepth - 1, cap_now));
      end else if (op == OpPoke) begin
        idx = AddrW'($urandom_range(cap_now - 1));
      end else begin
        for (int t = 0; t < 4 && !found && poked_slots.size() > 0; t++) begin
          k = poked_slots[$urandom_range(poked_slots.size() - 1)];
          if (k < cap_now) begin
            idx = AddrW'(k);
            found = 1'b1;
          end
        end
        if (!found) begin
          op = OpPoke;
          idx = AddrW'($urandom_range(cap_now - 1));
        end
      end
    end else if (roll < (push_lean ? 80 : 50)) begin
      op = OpPush;
    end else begin
      op = OpPop;
    end
    if (call_left == 0) call_left = $urandom_range(8, 1);
    call_left--;
    last = (call_left == 0);
    send_word(op, idx, ByteW'($urandom_range(255)), last);
  endtask

  initial begin : sink
    int unsigned held;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        m_ready <= 1'b0;
        for (held = 0; held < HoldCycles; held++) @(posedge clk_i);
        hold_req = 1'b0;
      end
      m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin : watchdog
    int unsigned ticks;
    for (ticks = 0; ticks < LimitCycles; ticks++) @(posedge clk_i);
    $display("Some tests failed");
    $finish;
  end

  initial begin : stimulus
    int unsigned caps [12];
    caps = '{2, 0, 3, 4, 1, 9, 33, 8191, 4097, 4096, 200, 0};
    caps[11] = $urandom_range(100, 5);
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_word(OpStatus, '0, '0, 1'b1);
    send_word(OpPop, '0, '0, 1'b1);
    send_word(OpPush, '0, 8'h00, 1'b0);
    send_word(OpPush, '0, 8'hFF, 1'b1);
    send_word(OpPoke, 12'd0, 8'hA5, 1'b1);
    send_word(OpPoke, 12'hFFF, 8'hFF, 1'b1);
    send_word(OpPeek, 12'hFFF, '0, 1'b1);
    send_word(OpPeek, 12'd0, '0, 1'b1);
    send_word(OpPop, '0, '0, 1'b1);
    send_word(OpPop, '0, '0, 1'b1);
    send_word(OpPop, '0, '0, 1'b1);
    send_word(OpSpare5, 12'hFFF, 8'hFF, 1'b1);
    send_word(OpSpare6, 12'hFFF, 8'hFF, 1'b0);
    send_word(OpSpare7, 12'hFFF, 8'hFF, 1'b1);
    write_capacity(3);
    send_word(OpStatus, '0, '0, 1'b1);
    send_word(OpPush, '0, 8'h11, 1'b0);
    send_word(OpPush, '0, 8'h22, 1'b0);
    send_word(OpPush, '0, 8'h33, 1'b1);
    send_word(OpPeek, 12'd3, '0, 1'b1);
    send_word(OpPoke, 12'hFFF, 8'h77, 1'b1);
    send_word(OpPoke, 12'd2, 8'h5A, 1'b1);
    send_word(OpPeek, 12'd2, '0, 1'b1);
    send_word(OpPop, '0, '0, 1'b0);
    send_word(OpPop, '0, '0, 1'b0);
    send_word(OpPop, '0, '0, 1'b1);

    write_capacity(16);
    hold_req = 1'b1;
    for (int i = 0; i < 40; i++) send_random_word(1'b1);

    foreach (caps[p]) begin
      bit push_lean;
      write_capacity(caps[p]);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
        default: begin send_idle_pct = 22; recv_stall_pct = 22; end
      endcase
      push_lean = 1'b1;
      for (int i = 0; i < PhaseWords; i++) begin
        if (i % 20 == 0) push_lean = 1'($urandom_range(1));
        send_random_word(push_lean);
      end
    end

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
